>>> sv/sbb_pkg.sv
// sbb_pkg: shared types and constants of the separable box blur.
// Fixed field widths, configuration register indexes and item codes.
// No dependencies.
package sbb_pkg;

  localparam int PIX_W      = 16;  // one channel, u8.8
  localparam int RAD_CFG_W  = 4;
  localparam int DIM_CFG_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [RAD_CFG_W-1:0] RADIUS_RST = 4'd2;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 11'd1024;

endpackage

>>> sv/sbb_ram.sv
// sbb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/separable_box_blur.sv
// separable_box_blur: streaming clipped-window box blur on u8.8 RGB pixels.
// Depends on sbb_pkg and sbb_ram (row-sum ring memory).
//
// Pixels arrive in raster order, one beat each; every pixel gets the floor of
// the sum over its (2r+1)x(2r+1) window, clipped to the frame, divided by the
// clipped pixel count. A result beat leaves once the last pixel of its window
// has come in; flush beats (operation = 1) drain the results of the last rows
// after the frame, one per beat, and a pixel beat after the frame's input is
// complete is dropped but drains like a flush. Radius, width and height are
// sampled at the first beat of each frame; writes mid-frame apply to the next
// frame. Radius above MAX_RADIUS acts as MAX_RADIUS, width and height of zero
// act as one and clamp to MAX_WIDTH / MAX_HEIGHT. One beat is handled at a
// time by a sequencer around a single row-sum memory of (2*MAX_RADIUS+1) rows
// by MAX_WIDTH entries. Each beat goes through accept, pixel update and a
// readiness check; the last pixel of a row adds the right-border fill of the
// row sums, and a result that leaves adds a memory read and accumulate step
// per window row (at most 2r+1 rows), the bit-serial divider and the load of
// the output register. A waiting result does not block the next beat from
// being accepted unless a second result is ready for it.
module separable_box_blur
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  pix_t                  red_in_i,
  input  pix_t                  green_in_i,
  input  pix_t                  blue_in_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_t                  red_out_o,
  output pix_t                  green_out_o,
  output pix_t                  blue_out_o,
  output logic                  frame_done_o
);

  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(RING);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CH_W  = PIX_W + $clog2(RING);
  localparam int SUM_W = PIX_W + $clog2(RING * RING);
  localparam int CNT_W = $clog2(RING * RING + 1);
  localparam int NW    = $clog2(RING + 1);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int XW    = (WW > DIM_CFG_W) ? WW + 1 : DIM_CFG_W + 1;
  localparam int YW    = (HW > DIM_CFG_W) ? HW + 1 : DIM_CFG_W + 1;
  localparam int CW    = WW + RW + 2;
  localparam int EW    = SW + 2;
  localparam int ACT_R_RST = (2 > MAX_RADIUS) ? MAX_RADIUS : 2;
  localparam int ACT_W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int ACT_H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PIX, ST_TAIL, ST_CHK, ST_RD, ST_ACC, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  // configuration and per-frame copies
  logic [RAD_CFG_W-1:0] cfg_radius_q;
  logic [DIM_CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic [RW-1:0]        act_r_q;
  logic [WW-1:0]        act_w_q;
  logic [HW-1:0]        act_h_q;

  // input side
  logic [WW-1:0]        ix_q;
  logic [HW-1:0]        iy_q;
  logic [SW-1:0]        islot_q, wp_q;
  logic [3*CH_W-1:0]    rs_q;
  logic [3*PIX_W-1:0]   recent_q [RING];
  logic [3*PIX_W-1:0]   pix_q;
  logic                 op_q;
  logic [WW-1:0]        c_q;
  logic [SW-1:0]        ti_q;

  // output side
  logic [WW-1:0]        ox_q;
  logic [HW-1:0]        oy_q;
  logic [SW-1:0]        oslot_q, rslot_q;
  logic [NW-1:0]        rows_q, nx_q, ny_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     sum_q [3];
  logic [CNT_W-1:0]     rem_q [3];
  logic [DCW-1:0]       div_cnt_q;
  logic                 last_q;
  logic                 out_valid_q, frame_done_q;
  pix_t                 out_q [3];

  // ---------------- configuration clamps ----------------
  logic [RW-1:0] r_clamp;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [XW-1:0] w_ext;
  logic [YW-1:0] h_ext;

  always_comb begin
    w_ext   = XW'(cfg_width_q);
    h_ext   = YW'(cfg_height_q);
    r_clamp = (cfg_radius_q > RAD_CFG_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(cfg_radius_q);
    if (w_ext == '0)                  w_clamp = WW'(1);
    else if (w_ext > XW'(MAX_WIDTH))  w_clamp = WW'(MAX_WIDTH);
    else                              w_clamp = WW'(w_ext);
    if (h_ext == '0)                  h_clamp = HW'(1);
    else if (h_ext > YW'(MAX_HEIGHT)) h_clamp = HW'(MAX_HEIGHT);
    else                              h_clamp = HW'(h_ext);
  end

  // ---------------- horizontal running sum ----------------
  logic [SW-1:0]      wp_eff, old_idx, rd_idx, ti_init, wp_next;
  logic [EW-1:0]      e_old, e_tail;
  logic [RW:0]        two_r1;
  logic               do_sub, tail_sub, sub_en, pix_en, row_end;
  logic [3*PIX_W-1:0] old_pix, add_pix;
  logic [3*CH_W-1:0]  rs_base, rs_new;

  always_comb begin
    wp_eff   = (ix_q == '0) ? '0 : wp_q;
    wp_next  = (wp_eff == SW'(RING - 1)) ? '0 : wp_eff + SW'(1);
    two_r1   = {act_r_q, 1'b1};
    do_sub   = CW'(ix_q) >= CW'(two_r1);
    tail_sub = CW'(c_q) >= CW'(act_r_q) + CW'(1);
    pix_en   = (op_q == OP_PIXEL) && (iy_q < act_h_q);
    row_end  = ix_q == act_w_q - WW'(1);
    // slot of the pixel leaving the horizontal window
    e_old    = EW'(wp_eff) + EW'(RING) - EW'(two_r1);
    old_idx  = (e_old >= EW'(RING)) ? SW'(e_old - EW'(RING)) : SW'(e_old);
    // first right-border subtraction slot when the row ends
    e_tail   = EW'(wp_eff) + EW'(RING) - EW'({act_r_q, 1'b0});
    if (CW'(ix_q) >= CW'(act_r_q)) begin
      ti_init = (e_tail >= EW'(RING)) ? SW'(e_tail - EW'(RING)) : SW'(e_tail);
    end else begin
      ti_init = SW'(RING - 1) - SW'(act_r_q);
    end
    rd_idx   = (state_q == ST_TAIL) ? ti_q : old_idx;
    old_pix  = recent_q[rd_idx];
    rs_base  = (state_q == ST_PIX && ix_q == '0) ? '0 : rs_q;
    sub_en   = (state_q == ST_PIX) ? do_sub : tail_sub;
    add_pix  = (state_q == ST_PIX) ? pix_q : '0;
    for (int k = 0; k < 3; k++) begin
      rs_new[k*CH_W +: CH_W] = rs_base[k*CH_W +: CH_W]
                             - (sub_en ? CH_W'(old_pix[k*PIX_W +: PIX_W]) : CH_W'(0))
                             + CH_W'(add_pix[k*PIX_W +: PIX_W]);
    end
  end

  // ---------------- row-sum memory ----------------
  logic          ram_we, ram_re;
  logic [WW-1:0] wcol;
  logic [AW-1:0] waddr, raddr;
  logic [3*CH_W-1:0] rdata;

  always_comb begin
    ram_we = 1'b0;
    wcol   = c_q;
    if (state_q == ST_PIX) begin
      ram_we = pix_en && (CW'(ix_q) >= CW'(act_r_q));
      wcol   = ix_q - WW'(act_r_q);
    end else if (state_q == ST_TAIL) begin
      ram_we = c_q < act_w_q;
    end
    waddr  = AW'(islot_q) * AW'(MAX_WIDTH) + AW'(wcol);
    ram_re = state_q == ST_RD;
    raddr  = AW'(rslot_q) * AW'(MAX_WIDTH) + AW'(ox_q);
  end

  sbb_ram #(
    .Width (3 * CH_W),
    .Depth (DEPTH)
  ) u_row_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (rs_new),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------- window bounds of the next result ----------------
  logic [WW:0]   x1s;
  logic [HW:0]   y1s;
  logic [WW-1:0] x1, x0;
  logic [HW-1:0] y1, y0;
  logic          avail;
  logic [SW-1:0] sslot;
  logic [EW-1:0] e_s;

  always_comb begin
    x1s   = (WW+1)'(ox_q) + (WW+1)'(act_r_q);
    y1s   = (HW+1)'(oy_q) + (HW+1)'(act_r_q);
    x1    = (x1s > (WW+1)'(act_w_q - WW'(1))) ? act_w_q - WW'(1) : WW'(x1s);
    y1    = (y1s > (HW+1)'(act_h_q - HW'(1))) ? act_h_q - HW'(1) : HW'(y1s);
    x0    = (CW'(ox_q) >= CW'(act_r_q)) ? ox_q - WW'(act_r_q) : '0;
    y0    = (CW'(oy_q) >= CW'(act_r_q)) ? oy_q - HW'(act_r_q) : '0;
    avail = (y1 < iy_q) || ((y1 == iy_q) && (x1 < ix_q));
    e_s   = EW'(oslot_q) + EW'(RING) - EW'(act_r_q);
    if (CW'(oy_q) >= CW'(act_r_q)) begin
      sslot = (e_s >= EW'(RING)) ? SW'(e_s - EW'(RING)) : SW'(e_s);
    end else begin
      sslot = '0;
    end
  end

  // ---------------- divider step ----------------
  logic [CNT_W:0]   trial [3];
  logic             ge [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], sum_q[k][SUM_W-1]};
      ge[k]    = trial[k] >= {1'b0, cnt_q};
    end
  end

  logic load_out;
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_radius_q <= RADIUS_RST;
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      act_r_q      <= RW'(ACT_R_RST);
      act_w_q      <= WW'(ACT_W_RST);
      act_h_q      <= HW'(ACT_H_RST);
      ix_q         <= '0;
      iy_q         <= '0;
      islot_q      <= '0;
      wp_q         <= '0;
      rs_q         <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      oslot_q      <= '0;
      out_valid_q  <= 1'b0;
      frame_done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_RADIUS: cfg_radius_q <= cfg_data_i[RAD_CFG_W-1:0];
          REG_WIDTH:  cfg_width_q  <= cfg_data_i[DIM_CFG_W-1:0];
          REG_HEIGHT: cfg_height_q <= cfg_data_i[DIM_CFG_W-1:0];
          default: ;
        endcase
      end

      // a reload in the same cycle keeps the output valid
      if (out_valid_q && out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (ix_q == '0 && iy_q == '0 && ox_q == '0 && oy_q == '0) begin
              act_r_q <= r_clamp;
              act_w_q <= w_clamp;
              act_h_q <= h_clamp;
            end
            op_q    <= operation_i;
            pix_q   <= {blue_in_i, green_in_i, red_in_i};
            state_q <= ST_PIX;
          end
        end
        ST_PIX: begin
          state_q <= ST_CHK;
          if (pix_en) begin
            rs_q             <= rs_new;
            recent_q[wp_eff] <= pix_q;
            wp_q             <= wp_next;
            if (row_end) begin
              c_q     <= (CW'(ix_q) >= CW'(act_r_q))
                         ? ix_q - WW'(act_r_q) + WW'(1) : '0;
              ti_q    <= ti_init;
              state_q <= ST_TAIL;
            end else begin
              ix_q <= ix_q + WW'(1);
            end
          end
        end
        ST_TAIL: begin
          if (c_q < act_w_q) begin
            rs_q <= rs_new;
            c_q  <= c_q + WW'(1);
            ti_q <= (ti_q == SW'(RING - 1)) ? '0 : ti_q + SW'(1);
          end else begin
            ix_q    <= '0;
            iy_q    <= iy_q + HW'(1);
            islot_q <= (islot_q == SW'(RING - 1)) ? '0 : islot_q + SW'(1);
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (avail) begin
            nx_q    <= NW'(x1 - x0 + WW'(1));
            ny_q    <= NW'(y1 - y0 + HW'(1));
            rows_q  <= NW'(y1 - y0 + HW'(1));
            rslot_q <= sslot;
            last_q  <= (ox_q == act_w_q - WW'(1)) && (oy_q == act_h_q - HW'(1));
            for (int k = 0; k < 3; k++) sum_q[k] <= '0;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD: begin
          cnt_q   <= CNT_W'(nx_q) * CNT_W'(ny_q);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          for (int k = 0; k < 3; k++) begin
            sum_q[k] <= sum_q[k] + SUM_W'(rdata[k*CH_W +: CH_W]);
            rem_q[k] <= '0;
          end
          rslot_q   <= (rslot_q == SW'(RING - 1)) ? '0 : rslot_q + SW'(1);
          rows_q    <= rows_q - NW'(1);
          div_cnt_q <= '0;
          state_q   <= (rows_q == NW'(1)) ? ST_DIV : ST_RD;
        end
        ST_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem_q[k] <= ge[k] ? CNT_W'(trial[k] - {1'b0, cnt_q}) : CNT_W'(trial[k]);
            sum_q[k] <= {sum_q[k][SUM_W-2:0], ge[k]};
          end
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(SUM_W - 1)) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            for (int k = 0; k < 3; k++) out_q[k] <= sum_q[k][PIX_W-1:0];
            out_valid_q  <= 1'b1;
            frame_done_q <= last_q;
            if (last_q) begin
              ox_q    <= '0;
              oy_q    <= '0;
              oslot_q <= '0;
              ix_q    <= '0;
              iy_q    <= '0;
              islot_q <= '0;
            end else if (ox_q == act_w_q - WW'(1)) begin
              ox_q    <= '0;
              oy_q    <= oy_q + HW'(1);
              oslot_q <= (oslot_q == SW'(RING - 1)) ? '0 : oslot_q + SW'(1);
            end else begin
              ox_q <= ox_q + WW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[0];
  assign green_out_o  = out_q[1];
  assign blue_out_o   = out_q[2];
  assign frame_done_o = frame_done_q;

  // ---------------- assertions ----------------
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && last_q |=> ix_q == '0 && iy_q == '0 && ox_q == '0 && oy_q == '0)
    else $error("positions not cleared at frame end");

  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oy_q <= iy_q)
    else $error("output row ahead of input row");

  a_rows_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iy_q <= act_h_q && ix_q < act_w_q)
    else $error("input position beyond frame");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q != '0)
    else $error("zero window count at divide");

  a_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    islot_q < SW'(RING) && oslot_q < SW'(RING) && wp_q < SW'(RING))
    else $error("ring slot out of range");

endmodule
